// File: hdl/rcfd_pkg.sv
`timescale 1ns / 1ps

package rcfd_pkg;

  localparam int NUM_CHANNELS = 14;
  localparam int CH_W         = 4;
  localparam int VALUE_W      = 11;
  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 16;
  localparam int POS_W        = 5;
  localparam int CFG_W        = 56;
  localparam int CFG_IDX_W    = 2;
  localparam int CH_PER_REG   = 7;
  localparam int PAYLOAD_LEN  = 28;
  localparam int PROD_W       = 21;
  localparam int RECIP_W      = 18;
  localparam int RECIP_SHIFT  = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_HIGH = 2'd1;

  localparam logic [BYTE_W-1:0]  HDR_FIRST  = 8'h20;
  localparam logic [BYTE_W-1:0]  HDR_SECOND = 8'h40;
  localparam logic [WORD_W-1:0]  RAW_MIN    = 16'd1000;
  localparam logic [WORD_W-1:0]  RAW_MAX    = 16'd2000;
  localparam logic [VALUE_W-1:0] FULL_SCALE = 11'd1000;
  localparam logic [WORD_W-1:0]  SUM_INIT   = 16'hFFFF;
  localparam logic [POS_W-1:0]   POS_HUNT   = 5'd0;
  localparam logic [POS_W-1:0]   POS_HDR2   = 5'd1;
  localparam logic [POS_W-1:0]   POS_DATA   = 5'd2;
  localparam logic [POS_W-1:0]   SUM_END    = 5'd30;
  localparam logic [POS_W-1:0]   POS_CSUM_H = 5'd31;

  // Division by 1000 is a shift by three followed by a reciprocal multiply for 125.
  localparam logic [RECIP_W-1:0] RECIP_125 = 18'd134218;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  typedef enum logic [4:0] {
    S_RECV = 5'b00001,
    S_READ = 5'b00010,
    S_MULT = 5'b00100,
    S_DIV  = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  typedef struct packed {
    logic            byte_take;
    logic            rd;
    logic            mult;
    logic            div;
    logic [CH_W-1:0] ch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_good;
  } ctrl_status_t;

endpackage

// File: hdl/rcfd_if.sv
`timescale 1ns / 1ps

interface rcfd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [rcfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfd_chan_if;
  logic                        valid;
  logic                        ready;
  logic [rcfd_pkg::CH_W-1:0]    channel_index;
  logic [rcfd_pkg::VALUE_W-1:0] channel_value;
  logic                        last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

interface rcfd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rcfd_pkg::CFG_IDX_W-1:0] index;
  logic [rcfd_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/rcfd_ctrl.sv
`timescale 1ns / 1ps

module rcfd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  output logic                   rx_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  input  rcfd_pkg::ctrl_status_t status,
  output rcfd_pkg::ctrl_cmd_t    cmd
);

  rcfd_pkg::state_t              state, state_next;
  logic [rcfd_pkg::CH_W-1:0]     ch, ch_next;

  assign rx_ready  = (state == rcfd_pkg::S_RECV);
  assign out_valid = (state == rcfd_pkg::S_SEND);

  assign cmd.byte_take = rx_valid && (state == rcfd_pkg::S_RECV);
  assign cmd.rd        = (state == rcfd_pkg::S_READ);
  assign cmd.mult      = (state == rcfd_pkg::S_MULT);
  assign cmd.div       = (state == rcfd_pkg::S_DIV);
  assign cmd.ch        = ch;

  always_comb begin
    state_next = state;
    ch_next    = ch;
    unique case (state)
      rcfd_pkg::S_RECV: begin
        if (cmd.byte_take && status.frame_good) begin
          state_next = rcfd_pkg::S_READ;
          ch_next    = '0;
        end
      end
      rcfd_pkg::S_READ: state_next = rcfd_pkg::S_MULT;
      rcfd_pkg::S_MULT: state_next = rcfd_pkg::S_DIV;
      rcfd_pkg::S_DIV:  state_next = rcfd_pkg::S_SEND;
      rcfd_pkg::S_SEND: begin
        if (out_ready) begin
          if (ch == rcfd_pkg::LAST_CH) begin
            state_next = rcfd_pkg::S_RECV;
          end else begin
            state_next = rcfd_pkg::S_READ;
            ch_next    = ch + 1'b1;
          end
        end
      end
      default: state_next = rcfd_pkg::S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcfd_pkg::S_RECV;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

endmodule

// File: hdl/rcfd_datapath.sv
`timescale 1ns / 1ps

module rcfd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rcfd_pkg::ctrl_cmd_t           cmd,
  output rcfd_pkg::ctrl_status_t        status,
  input  logic [rcfd_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          cfg_we,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcfd_pkg::CFG_W-1:0]     cfg_data,
  output logic [rcfd_pkg::CH_W-1:0]      channel_index,
  output logic [rcfd_pkg::VALUE_W-1:0]   channel_value,
  output logic                          last_channel
);

  logic [rcfd_pkg::CFG_W-1:0]   cal_low, cal_high;
  logic [rcfd_pkg::POS_W-1:0]   pos, pos_next;
  logic [rcfd_pkg::WORD_W-1:0]  csum, csum_next;
  logic [rcfd_pkg::BYTE_W-1:0]  csum_lo;
  logic [rcfd_pkg::WORD_W-1:0]  byte_ext;
  logic                         store_we;
  logic [rcfd_pkg::POS_W-1:0]   store_addr;

  logic [rcfd_pkg::BYTE_W-1:0]  frame_mem [rcfd_pkg::PAYLOAD_LEN];
  logic [rcfd_pkg::BYTE_W-1:0]  raw_lo, raw_hi, cal_q;
  logic [rcfd_pkg::BYTE_W-1:0]  cal_sel;
  logic [2:0]                   cal_slot;

  logic [rcfd_pkg::WORD_W-1:0]  diff;
  logic [rcfd_pkg::WORD_W-1:0]  offset;
  logic [rcfd_pkg::VALUE_W-1:0] gain;
  logic [2*rcfd_pkg::VALUE_W-1:0] prod_full;
  logic [rcfd_pkg::PROD_W-1:0]  prod;
  logic [2*rcfd_pkg::RECIP_W-1:0] quot_full;
  logic                         in_range;

  assign byte_ext = {{(rcfd_pkg::WORD_W-rcfd_pkg::BYTE_W){1'b0}}, rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_low  <= '0;
      cal_high <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rcfd_pkg::CFG_CAL_LOW) begin
        cal_low <= cfg_data;
      end else if (cfg_index == rcfd_pkg::CFG_CAL_HIGH) begin
        cal_high <= cfg_data;
      end
    end
  end

  // Header hunt, running checksum, payload store address and checksum compare.
  always_comb begin
    pos_next          = pos;
    csum_next         = csum;
    store_we          = 1'b0;
    store_addr        = pos - rcfd_pkg::POS_DATA;
    status.frame_good = 1'b0;
    if (pos == rcfd_pkg::POS_HUNT) begin
      if (rx_byte == rcfd_pkg::HDR_FIRST) begin
        pos_next  = rcfd_pkg::POS_HDR2;
        csum_next = rcfd_pkg::SUM_INIT - byte_ext;
      end else begin
        csum_next = rcfd_pkg::SUM_INIT;
      end
    end else if (pos == rcfd_pkg::POS_HDR2) begin
      if (rx_byte == rcfd_pkg::HDR_SECOND) begin
        pos_next  = rcfd_pkg::POS_DATA;
        csum_next = csum - byte_ext;
      end else if (rx_byte == rcfd_pkg::HDR_FIRST) begin
        csum_next = rcfd_pkg::SUM_INIT - byte_ext;
      end else begin
        pos_next  = rcfd_pkg::POS_HUNT;
        csum_next = rcfd_pkg::SUM_INIT;
      end
    end else if (pos < rcfd_pkg::SUM_END) begin
      store_we  = 1'b1;
      csum_next = csum - byte_ext;
      pos_next  = pos + 1'b1;
    end else if (pos == rcfd_pkg::SUM_END) begin
      pos_next = rcfd_pkg::POS_CSUM_H;
    end else begin
      status.frame_good = ({rx_byte, csum_lo} == csum);
      pos_next          = rcfd_pkg::POS_HUNT;
      csum_next         = rcfd_pkg::SUM_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= rcfd_pkg::POS_HUNT;
      csum    <= rcfd_pkg::SUM_INIT;
      csum_lo <= '0;
    end else if (cmd.byte_take) begin
      pos  <= pos_next;
      csum <= csum_next;
      if (pos == rcfd_pkg::SUM_END) begin
        csum_lo <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_take && store_we) begin
      frame_mem[store_addr] <= rx_byte;
    end
  end

  // Calibration byte of the current channel.
  always_comb begin
    if (cmd.ch < rcfd_pkg::CH_W'(rcfd_pkg::CH_PER_REG)) begin
      cal_slot = cmd.ch[2:0];
      cal_sel  = cal_low[cal_slot*rcfd_pkg::BYTE_W +: rcfd_pkg::BYTE_W];
    end else begin
      cal_slot = 3'(cmd.ch - rcfd_pkg::CH_W'(rcfd_pkg::CH_PER_REG));
      cal_sel  = cal_high[cal_slot*rcfd_pkg::BYTE_W +: rcfd_pkg::BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      raw_lo <= frame_mem[{cmd.ch, 1'b0}];
      raw_hi <= frame_mem[{cmd.ch, 1'b1}];
      cal_q  <= cal_sel;
    end
  end

  assign diff      = {raw_hi, raw_lo} - {{(rcfd_pkg::WORD_W-rcfd_pkg::BYTE_W){1'b0}}, cal_q};
  assign in_range  = (diff >= rcfd_pkg::RAW_MIN) && (diff <= rcfd_pkg::RAW_MAX);
  assign offset    = diff - rcfd_pkg::RAW_MIN;
  assign gain      = rcfd_pkg::FULL_SCALE +
                     {{(rcfd_pkg::VALUE_W-rcfd_pkg::BYTE_W){1'b0}}, cal_q};
  assign prod_full = offset[rcfd_pkg::VALUE_W-1:0] * gain;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod <= in_range ? prod_full[rcfd_pkg::PROD_W-1:0] : '0;
    end
  end

  assign quot_full = prod[rcfd_pkg::PROD_W-1:3] * rcfd_pkg::RECIP_125;

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      channel_value <= quot_full[rcfd_pkg::RECIP_SHIFT +: rcfd_pkg::VALUE_W];
      channel_index <= cmd.ch;
      last_channel  <= (cmd.ch == rcfd_pkg::LAST_CH);
    end
  end

endmodule

// File: hdl/rc_channel_frame_decoder_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// rx       in         rx_byte (8 bits)
// chan     out        channel_index (4), channel_value (11), last_channel (1)
// cfg      in         index (2), data (56)
//
// A received byte is taken whenever the block waits for input. After the last byte of a frame with a good
// checksum, the block emits 14 results, each passing through payload memory read,
// calibration multiply, reciprocal multiply, and the output beat.
// Input is held off until the last result of the frame has been taken.
// Reset is synchronous and returns the block to hunting for a header.
// A stalled output holds its result and keeps the input side stalled.
module rc_channel_frame_decoder_top (
  input logic        clk,
  input logic        rst,
  rcfd_byte_if.sink  rx,
  rcfd_chan_if.source chan,
  rcfd_cfg_if.sink   cfg
);

  rcfd_pkg::ctrl_cmd_t    cmd;
  rcfd_pkg::ctrl_status_t status;

  assign cfg.ready = 1'b1;

  rcfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .out_ready (chan.ready),
    .out_valid (chan.valid),
    .status    (status),
    .cmd       (cmd)
  );

  rcfd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rx_byte       (rx.rx_byte),
    .cfg_we        (cfg.valid && cfg.ready),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .channel_index (chan.channel_index),
    .channel_value (chan.channel_value),
    .last_channel  (chan.last_channel)
  );

endmodule

// File: hdl/rcfd_checker.sv
`timescale 1ns / 1ps

module rcfd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rx_valid,
  input logic                         rx_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rcfd_pkg::CH_W-1:0]    channel_index,
  input logic [rcfd_pkg::VALUE_W-1:0] channel_value,
  input logic                         last_channel
);

  // Bytes are never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rx_valid && rx_ready && out_valid))
    else $error("byte accepted while a result is pending");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_channel == (channel_index == rcfd_pkg::LAST_CH)))
    else $error("last_channel does not match channel_index");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_channel) |=>
      (!out_valid || channel_index == $past(channel_index) + 1'b1))
    else $error("channel results out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(channel_index) && $stable(channel_value)))
    else $error("stalled result changed");

endmodule

bind rc_channel_frame_decoder_top rcfd_checker u_rcfd_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_valid      (rx.valid),
  .rx_ready      (rx.ready),
  .out_valid     (chan.valid),
  .out_ready     (chan.ready),
  .channel_index (chan.channel_index),
  .channel_value (chan.channel_value),
  .last_channel  (chan.last_channel)
);
